### hdl/calibrated_temperature_converter_core_assert.svh
// Assertion macros for the calibrated temperature converter core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CALIBRATED_TEMPERATURE_CONVERTER_CORE_ASSERT_SVH
`define CALIBRATED_TEMPERATURE_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CTC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ctc_pkg.sv
// Shared types, constants and the fuse half decoder for the converter core.
// No dependencies.
package ctc_pkg;

  localparam int NUM_CHANNELS_DEF = 14;

  localparam int REQ_W       = 2;
  localparam int CHAN_W      = 4;
  localparam int EFUSE_W     = 32;
  localparam int RAW_W       = 16;
  localparam int TEMP_W      = 32;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  localparam int PT_W   = 8;
  localparam int GAIN_W = 17;
  localparam int OFFS_W = 24;
  localparam int DIVD_W = 23;
  localparam int DIVS_W = 17;
  localparam int Q_W    = 6;
  localparam int SCL_W  = 11;
  localparam int SLP_W  = 8;

  localparam int SHIFT_W     = 12;
  localparam int DEF_Y       = 56560;
  localparam int DEF_K_NEG   = 14120;
  localparam int PCT         = 100;
  localparam int T_HOT       = 85;
  localparam int T_COLD      = -40;
  localparam int GAIN_MAX    = 131071;
  localparam int GAIN_NUM    = 5656000;
  localparam int QN_MUL      = 10000;
  localparam int QN_BIAS     = 1412000;
  localparam int OFF_BIAS    = 400000;
  localparam int SLOPE_RECIP = 205;
  localparam int SLOPE_SH    = 10;
  // floor(n / DEF_Y) == (n * Q_RECIP) >> Q_SH for every n below 2**21
  localparam int Q_RECIP     = 1214984;
  localparam int Q_SH        = 36;
  localparam int FUSE_SH     = 11;
  localparam logic [5:0] FUSE_ONES = 6'h3F;

  typedef logic [REQ_W-1:0] ctc_req_t;
  localparam ctc_req_t REQ_COLD = 2'd0;
  localparam ctc_req_t REQ_HOT  = 2'd1;
  localparam ctc_req_t REQ_CONV = 2'd2;
  localparam ctc_req_t REQ_RSVD = 2'd3;

  typedef logic [STAT_W-1:0] ctc_stat_t;
  localparam ctc_stat_t STATUS_OK   = 2'd0;
  localparam ctc_stat_t STATUS_BAD  = 2'd1;
  localparam ctc_stat_t STATUS_ZERO = 2'd2;

  typedef logic [2:0] ctc_cmd_t;
  localparam ctc_cmd_t CMD_FAIL = 3'd0;
  localparam ctc_cmd_t CMD_ZERO = 3'd1;
  localparam ctc_cmd_t CMD_COLD = 3'd2;
  localparam ctc_cmd_t CMD_HOT  = 3'd3;
  localparam ctc_cmd_t CMD_CONV = 3'd4;

  typedef struct packed {
    ctc_cmd_t                cmd;
    logic [CHAN_W-1:0]       idx;
    logic                    has_odd;
    logic signed [PT_W-1:0]  val_even;
    logic signed [PT_W-1:0]  val_odd;
    logic [RAW_W-1:0]        raw;
  } ctc_qent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ctc_qstat_t;

  function automatic logic signed [PT_W-1:0] decode_half(input logic [15:0] half,
                                                         input logic hot);
    logic [15:0] d;
    logic [4:0] mag;
    logic signed [PT_W-1:0] base;
    d    = (half[5:0] == FUSE_ONES) ? (half >> FUSE_SH) : half;
    mag  = {d[1], d[2], d[3], d[4], d[5]};
    base = hot ? PT_W'(T_HOT) : PT_W'(T_COLD);
    return d[0] ? (base - $signed({3'b000, mag})) : (base + $signed({3'b000, mag}));
  endfunction

endpackage

### hdl/calibrated_temperature_converter_core.sv
// Calibrated temperature converter core, top level. Depends on ctc_pkg, ctc_front,
// ctc_queue, ctc_back and the assertion header.
// One result transaction per input transaction, in order. A two-entry queue lets the
// input side keep accepting while the execution side works or the result waits.
// Cold loads, rejected requests and zero samples finish in the idle state; a convert
// steps through scale, multiply and output (the multiply is skipped on the default line).
// A hot load derives the line for the even channel and, for a full pair, then the odd
// one: per channel, setup, the one-bit-per-cycle divider (23 steps) for the gain, the
// offset quotient by reciprocal multiply, the offset product and the write-back.
`include "calibrated_temperature_converter_core_assert.svh"

module calibrated_temperature_converter_core #(
  parameter int NUM_CHANNELS = ctc_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // req_type[1:0], channel[5:2], efuse_word[37:6], raw_sample[53:38], zero pad
  input  logic [ctc_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // temperature[31:0], status[33:32], zero pad
  output logic [ctc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ctc_pkg::*;

  ctc_qstat_t qstat;
  ctc_qent_t  ent;
  ctc_qent_t  head;
  logic       push;
  logic       pop;

  ctc_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .qstat     (qstat),
    .push      (push),
    .ent       (ent)
  );

  ctc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (ent),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  ctc_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .qstat      (qstat),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `CTC_ASSERT_NOW(a_pop_nonempty, pop, !qstat.empty, "pop from empty command queue")
  `CTC_ASSERT_NEXT(a_push_fills, in_tvalid && in_tready, !qstat.empty, "queue lost a push")
  `CTC_ASSERT_NOW(a_full_by_push, $rose(qstat.full), $past(in_tvalid && in_tready), "queue filled without push")

endmodule

### hdl/ctc_div.sv
// Restoring divider, one quotient bit per cycle, shared by the calibration path.
// Depends on ctc_pkg.
module ctc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ctc_pkg::DIVD_W-1:0] dividend,
  input  logic [ctc_pkg::DIVS_W-1:0] divisor,
  output logic                       done,
  output logic [ctc_pkg::DIVD_W-1:0] quotient
);
  import ctc_pkg::*;

  localparam int CNT_W = $clog2(DIVD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W+1:0] diff;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVD_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVD_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIVD_W-2:0], ~diff[DIVS_W+1]};
      rem_nxt = diff[DIVS_W+1] ? rem_sh[DIVS_W-1:0] : diff[DIVS_W-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### hdl/ctc_front.sv
// Input side: unpacks a transaction, range-checks it and decodes fuse halves.
// Depends on ctc_pkg.
module ctc_front #(
  parameter int NUM_CHANNELS = ctc_pkg::NUM_CHANNELS_DEF
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ctc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  ctc_pkg::ctc_qstat_t            qstat,
  output logic                           push,
  output ctc_pkg::ctc_qent_t             ent
);
  import ctc_pkg::*;

  localparam logic [5:0] NCH = 6'(NUM_CHANNELS);

  ctc_req_t           req;
  logic [CHAN_W-1:0]  chan;
  logic [EFUSE_W-1:0] fuse;
  logic [RAW_W-1:0]   raw;
  logic [5:0]         even;
  logic [5:0]         odd;
  logic               hot;

  always_comb begin
    req  = in_tdata[1:0];
    chan = in_tdata[5:2];
    fuse = in_tdata[37:6];
    raw  = in_tdata[53:38];
    even = {1'b0, chan, 1'b0};
    odd  = even + 6'd1;
    hot  = (req == REQ_HOT);

    ent.cmd      = CMD_FAIL;
    ent.idx      = chan;
    ent.has_odd  = 1'b0;
    ent.val_even = decode_half(fuse[15:0], hot);
    ent.val_odd  = decode_half(fuse[31:16], hot);
    ent.raw      = raw;

    unique case (req) inside
      REQ_COLD, REQ_HOT: begin
        if (even < NCH) begin
          ent.cmd     = hot ? CMD_HOT : CMD_COLD;
          ent.idx     = even[CHAN_W-1:0];
          ent.has_odd = (odd < NCH);
        end
      end
      REQ_CONV: begin
        if ({2'b00, chan} >= NCH) begin
          ent.cmd = CMD_FAIL;
        end else if (raw == '0) begin
          ent.cmd = CMD_ZERO;
        end else begin
          ent.cmd = CMD_CONV;
        end
      end
      default: ent.cmd = CMD_FAIL;
    endcase
  end

  assign in_tready = ~qstat.full;
  assign push      = in_tvalid & ~qstat.full;

endmodule

### hdl/ctc_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on ctc_pkg.
module ctc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ctc_pkg::ctc_qent_t  din,
  input  logic                pop,
  output ctc_pkg::ctc_qent_t  head,
  output ctc_pkg::ctc_qstat_t qstat
);
  import ctc_pkg::*;

  ctc_qent_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) mem_r[wr_ptr_r] <= din;
  end

  assign head        = mem_r[rd_ptr_r];
  assign qstat.empty = (cnt_r == 2'd0);
  assign qstat.full  = (cnt_r == 2'd2);

endmodule

### hdl/ctc_back.sv
// Execution side: per-channel calibration store, line derivation, conversion
// and the result register. Depends on ctc_pkg and ctc_div.
module ctc_back #(
  parameter int NUM_CHANNELS = ctc_pkg::NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ctc_pkg::ctc_qstat_t             qstat,
  input  ctc_pkg::ctc_qent_t              head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ctc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ctc_pkg::*;

  localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int OUT_PAD = OUT_TDATA_W - TEMP_W - STAT_W;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CVSC = 4'd1;
  localparam logic [3:0] ST_CVML = 4'd2;
  localparam logic [3:0] ST_CVOT = 4'd3;
  localparam logic [3:0] ST_HPRP = 4'd4;
  localparam logic [3:0] ST_HYST = 4'd5;
  localparam logic [3:0] ST_HYWT = 4'd6;
  localparam logic [3:0] ST_HQST = 4'd7;
  localparam logic [3:0] ST_HMUL = 4'd8;
  localparam logic [3:0] ST_HWB  = 4'd9;

  logic signed [PT_W-1:0]   cold_pt_r  [NUM_CHANNELS];
  logic signed [PT_W-1:0]   hot_pt_r   [NUM_CHANNELS];
  logic [GAIN_W-1:0]        gain_y_r   [NUM_CHANNELS];
  logic signed [OFFS_W-1:0] offset_k_r [NUM_CHANNELS];

  logic [3:0]               state_r, state_nxt;
  logic [CH_W-1:0]          ix_r, ix_nxt;
  logic                     odd_r, odd_nxt;
  logic [RAW_W-1:0]         raw_r, raw_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic [OFFS_W-1:0]        offs_r, offs_nxt;
  logic                     dflt_r, dflt_nxt;
  logic [SCL_W-1:0]         scl_r, scl_nxt;
  logic [TEMP_W-1:0]        prod_r, prod_nxt;
  logic [17:0]              t_r, t_nxt;
  logic [DIVD_W-1:0]        qn_r, qn_nxt;
  logic [GAIN_W-1:0]        y_r, y_nxt;
  logic [Q_W-1:0]           q_r, q_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;

  logic                     out_free;
  logic                     res_we;
  logic [TEMP_W-1:0]        res_temp;
  ctc_stat_t                res_stat;
  logic                     cold_we_e, cold_we_o, hot_we_e, hot_we_o, line_we;
  logic [CH_W-1:0]          ix_hd, ix_hd_odd;
  logic signed [PT_W-1:0]   cold_rd, hot_rd;
  logic signed [PT_W:0]     pt_diff;
  logic [9:0]               nsl;
  logic signed [23:0]       cold_x, qn_full;
  logic [22:0]              raw100;
  logic [SLP_W-1:0]         slope;
  logic signed [OFFS_W:0]   off_full;
  logic [43:0]              q_prod;

  logic                     div_start;
  logic [DIVD_W-1:0]        div_dividend;
  logic [DIVS_W-1:0]        div_divisor;
  logic                     div_done;
  logic [DIVD_W-1:0]        div_quot;

  ctc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    out_free  = ~out_valid_r | out_tready;
    ix_hd     = head.idx[CH_W-1:0];
    ix_hd_odd = ix_hd + CH_W'(1);
    cold_rd   = cold_pt_r[ix_r];
    hot_rd    = hot_pt_r[ix_r];
    pt_diff   = {hot_rd[PT_W-1], hot_rd} - {cold_rd[PT_W-1], cold_rd};
    nsl       = {pt_diff[PT_W-1:0], 2'b00};
    cold_x    = {{(24-PT_W){cold_rd[PT_W-1]}}, cold_rd};
    qn_full   = cold_x * 24'(QN_MUL) + 24'(QN_BIAS);
    raw100    = 23'(raw_r) * 23'(PCT);
    slope     = t_r[SLOPE_SH +: SLP_W];
    off_full  = 25'sd0 - $signed({2'b00, prod_r[DIVD_W-1:0]}) - 25'(OFF_BIAS);
    q_prod    = 44'(qn_r) * 44'(Q_RECIP);

    state_nxt = state_r;
    ix_nxt    = ix_r;
    odd_nxt   = odd_r;
    raw_nxt   = raw_r;
    gain_nxt  = gain_r;
    offs_nxt  = offs_r;
    dflt_nxt  = dflt_r;
    scl_nxt   = scl_r;
    prod_nxt  = prod_r;
    t_nxt     = t_r;
    qn_nxt    = qn_r;
    y_nxt     = y_r;
    q_nxt     = q_r;

    pop          = 1'b0;
    res_we       = 1'b0;
    res_temp     = '0;
    res_stat     = STATUS_OK;
    cold_we_e    = 1'b0;
    cold_we_o    = 1'b0;
    hot_we_e     = 1'b0;
    hot_we_o     = 1'b0;
    line_we      = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty && out_free) begin
          pop     = 1'b1;
          ix_nxt  = ix_hd;
          odd_nxt = head.has_odd;
          raw_nxt = head.raw;
          unique case (head.cmd)
            CMD_COLD: begin
              cold_we_e = 1'b1;
              cold_we_o = head.has_odd;
              res_we    = 1'b1;
            end
            CMD_HOT: begin
              hot_we_e  = 1'b1;
              hot_we_o  = head.has_odd;
              state_nxt = ST_HPRP;
            end
            CMD_CONV: state_nxt = ST_CVSC;
            CMD_ZERO: begin
              res_we   = 1'b1;
              res_stat = STATUS_ZERO;
            end
            default: begin
              res_we   = 1'b1;
              res_stat = STATUS_BAD;
            end
          endcase
        end
      end
      ST_CVSC: begin
        gain_nxt  = gain_y_r[ix_r];
        offs_nxt  = offset_k_r[ix_r];
        dflt_nxt  = (gain_y_r[ix_r] == '0) && (offset_k_r[ix_r] == '0);
        prod_nxt  = 32'(raw_r) * 32'(DEF_Y);
        scl_nxt   = raw100[SHIFT_W +: SCL_W];
        state_nxt = dflt_nxt ? ST_CVOT : ST_CVML;
      end
      ST_CVML: begin
        prod_nxt  = 32'(scl_r) * 32'(gain_r);
        state_nxt = ST_CVOT;
      end
      ST_CVOT: begin
        res_we    = 1'b1;
        res_temp  = dflt_r ? (32'(prod_r >> SHIFT_W) + 32'(DEF_K_NEG))
                           : (prod_r + {{(TEMP_W-OFFS_W){offs_r[OFFS_W-1]}}, offs_r});
        state_nxt = ST_IDLE;
      end
      ST_HPRP: begin
        t_nxt     = 18'(nsl) * 18'(SLOPE_RECIP);
        qn_nxt    = qn_full[DIVD_W-1:0];
        state_nxt = ST_HYST;
      end
      ST_HYST: begin
        if (slope == '0) begin
          y_nxt     = GAIN_W'(GAIN_MAX);
          state_nxt = ST_HQST;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIVD_W'(GAIN_NUM);
          div_divisor  = {{(DIVS_W-SLP_W){1'b0}}, slope};
          state_nxt    = ST_HYWT;
        end
      end
      ST_HYWT: begin
        if (div_done) begin
          y_nxt     = (div_quot > DIVD_W'(GAIN_MAX)) ? GAIN_W'(GAIN_MAX)
                                                     : div_quot[GAIN_W-1:0];
          state_nxt = ST_HQST;
        end
      end
      ST_HQST: begin
        q_nxt     = q_prod[Q_SH +: Q_W];
        state_nxt = ST_HMUL;
      end
      ST_HMUL: begin
        prod_nxt  = 32'(q_r) * 32'(y_r);
        state_nxt = ST_HWB;
      end
      ST_HWB: begin
        line_we = 1'b1;
        if (odd_r && !ix_r[0]) begin
          ix_nxt    = ix_r + CH_W'(1);
          state_nxt = ST_HPRP;
        end else begin
          res_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    if (res_we) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{OUT_PAD{1'b0}}, res_stat, res_temp};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cold_pt_r[i]  <= '0;
        hot_pt_r[i]   <= '0;
        gain_y_r[i]   <= '0;
        offset_k_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cold_we_e) cold_pt_r[ix_hd]    <= head.val_even;
      if (cold_we_o) cold_pt_r[ix_hd_odd] <= head.val_odd;
      if (hot_we_e)  hot_pt_r[ix_hd]     <= head.val_even;
      if (hot_we_o)  hot_pt_r[ix_hd_odd]  <= head.val_odd;
      if (line_we) begin
        gain_y_r[ix_r]   <= y_r;
        offset_k_r[ix_r] <= off_full[OFFS_W-1:0];
      end
    end
    ix_r       <= ix_nxt;
    odd_r      <= odd_nxt;
    raw_r      <= raw_nxt;
    gain_r     <= gain_nxt;
    offs_r     <= offs_nxt;
    dflt_r     <= dflt_nxt;
    scl_r      <= scl_nxt;
    prod_r     <= prod_nxt;
    t_r        <= t_nxt;
    qn_r       <= qn_nxt;
    y_r        <= y_nxt;
    q_r        <= q_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
